[rtl/rslp_pkg.sv]
// Package for the radix-suffix literal parser: payload structs, parse state
// types, character codes and format codes. No dependencies.

package rslp_pkg;

    localparam int unsigned DecW = 17;
    localparam int unsigned ValW = 16;
    localparam int unsigned ProdW = 20;

    localparam logic [DecW-1:0] DEC_SAT  = 17'd65537;
    localparam logic [DecW-1:0] NEG_BASE = 17'd65536;
    localparam logic [DecW-1:0] VAL_MAX  = 17'd65535;

    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_B = 8'h42;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_UPPER_H = 8'h48;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_H = 8'h68;

    localparam logic [1:0] FMT_DEC  = 2'd0;
    localparam logic [1:0] FMT_HEX  = 2'd1;
    localparam logic [1:0] FMT_BIN  = 2'd2;
    localparam logic [1:0] FMT_NONE = 2'd3;

    localparam logic [ValW-1:0] MAX_RESET = 16'hFFFF;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_final;
    } req_t;

    typedef struct packed {
        logic            ok;
        logic [ValW-1:0] value;
        logic [1:0]      format;
    } rsp_t;

    // decimal reading, updated with every character including the final one
    typedef struct packed {
        logic [DecW-1:0] accum;
        logic            still_ok;
        logic            minus_seen;
        logic            digit_seen;
    } dec_state_t;

    typedef struct packed {
        dec_state_t      dec;
        logic [ValW-1:0] hex_accum;
        logic [ValW-1:0] bin_accum;
        logic            hex_overflow;
        logic            bin_overflow;
        logic            hex_still_ok;
        logic            bin_still_ok;
        logic            chars_seen;
    } parse_state_t;

endpackage

[rtl/rslp_state.sv]
// Running parse state of the literal parser: decimal, hex and binary
// readings advanced one character per transaction. Depends on rslp_pkg.

module rslp_state
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  rslp_pkg::req_t        item,
    output rslp_pkg::parse_state_t cur,
    output rslp_pkg::dec_state_t  dec_upd
);

    rslp_pkg::parse_state_t state_reg;
    rslp_pkg::parse_state_t state_next;

    logic [7:0]                 c;
    logic                       is_dec;
    logic                       is_hex;
    logic [3:0]                 hex_val;
    logic [3:0]                 dec_val;
    logic [rslp_pkg::ProdW-1:0] prod;

    assign c   = item.char_code;
    assign cur = state_reg;

    always_comb
    begin
        is_dec  = (c >= rslp_pkg::CH_ZERO) && (c <= rslp_pkg::CH_NINE);
        dec_val = 4'(c - rslp_pkg::CH_ZERO);
        is_hex  = 1'b1;
        hex_val = dec_val;
        if (is_dec)
        begin
            hex_val = dec_val;
        end
        else if ((c >= rslp_pkg::CH_UPPER_A) && (c <= rslp_pkg::CH_UPPER_F))
        begin
            hex_val = 4'(c - rslp_pkg::CH_UPPER_A + 8'd10);
        end
        else if ((c >= rslp_pkg::CH_LOWER_A) && (c <= rslp_pkg::CH_LOWER_F))
        begin
            hex_val = 4'(c - rslp_pkg::CH_LOWER_A + 8'd10);
        end
        else
        begin
            is_hex = 1'b0;
        end

        prod = ({3'b000, state_reg.dec.accum} << 3) + ({3'b000, state_reg.dec.accum} << 1)
             + {16'd0, dec_val};

        dec_upd = state_reg.dec;
        if (!state_reg.chars_seen && (c == rslp_pkg::CH_MINUS))
        begin
            dec_upd.minus_seen = 1'b1;
        end
        else if (is_dec)
        begin
            dec_upd.digit_seen = 1'b1;
            // saturate so the magnitude never grows past the invalid mark
            if (prod > {3'b000, rslp_pkg::DEC_SAT})
            begin
                dec_upd.accum = rslp_pkg::DEC_SAT;
            end
            else
            begin
                dec_upd.accum = prod[rslp_pkg::DecW-1:0];
            end
        end
        else
        begin
            dec_upd.still_ok = 1'b0;
        end

        state_next = state_reg;
        if (item.is_final)
        begin
            state_next = '0;
            state_next.dec.still_ok = 1'b1;
            state_next.hex_still_ok = 1'b1;
            state_next.bin_still_ok = 1'b1;
        end
        else
        begin
            state_next.dec = dec_upd;
            if (is_hex)
            begin
                if (state_reg.hex_accum[15:12] != 4'd0)
                begin
                    state_next.hex_overflow = 1'b1;
                end
                state_next.hex_accum = {state_reg.hex_accum[11:0], hex_val};
            end
            else
            begin
                state_next.hex_still_ok = 1'b0;
            end
            if ((c == rslp_pkg::CH_ZERO) || (c == rslp_pkg::CH_ONE))
            begin
                if (state_reg.bin_accum[15])
                begin
                    state_next.bin_overflow = 1'b1;
                end
                state_next.bin_accum = {state_reg.bin_accum[14:0], c[0]};
            end
            else
            begin
                state_next.bin_still_ok = 1'b0;
            end
            state_next.chars_seen = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg              <= '0;
            state_reg.dec.still_ok <= 1'b1;
            state_reg.hex_still_ok <= 1'b1;
            state_reg.bin_still_ok <= 1'b1;
        end
        else if (step)
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/rslp_resolve.sv]
// Final-character decision of the literal parser: picks decimal, hex, binary or
// none and checks the value against the max register. Depends on rslp_pkg.

module rslp_resolve
(
    input  rslp_pkg::parse_state_t        cur,
    input  rslp_pkg::dec_state_t          dec_upd,
    input  logic [7:0]                    char_code,
    input  logic [rslp_pkg::ValW-1:0]     max_value,
    output rslp_pkg::rsp_t                result
);

    logic                        good;
    logic [rslp_pkg::ValW-1:0]   v;
    logic [1:0]                  fmt;
    logic [rslp_pkg::DecW-1:0]   neg_val;
    logic                        is_h;
    logic                        is_b;

    assign neg_val = rslp_pkg::NEG_BASE - dec_upd.accum;
    assign is_h = (char_code == rslp_pkg::CH_UPPER_H) || (char_code == rslp_pkg::CH_LOWER_H);
    assign is_b = (char_code == rslp_pkg::CH_UPPER_B) || (char_code == rslp_pkg::CH_LOWER_B);

    always_comb
    begin
        good = 1'b0;
        v    = '0;
        fmt  = rslp_pkg::FMT_NONE;
        if (dec_upd.still_ok && dec_upd.digit_seen)
        begin
            fmt = rslp_pkg::FMT_DEC;
            if (dec_upd.minus_seen && (dec_upd.accum != '0))
            begin
                good = (dec_upd.accum <= rslp_pkg::NEG_BASE);
                v    = neg_val[rslp_pkg::ValW-1:0];
            end
            else
            begin
                good = (dec_upd.accum <= rslp_pkg::VAL_MAX);
                v    = dec_upd.accum[rslp_pkg::ValW-1:0];
            end
        end
        else if (is_h && cur.chars_seen && cur.hex_still_ok)
        begin
            fmt  = rslp_pkg::FMT_HEX;
            good = !cur.hex_overflow;
            v    = cur.hex_accum;
        end
        else if (is_b && cur.chars_seen && cur.bin_still_ok)
        begin
            fmt  = rslp_pkg::FMT_BIN;
            good = !cur.bin_overflow;
            v    = cur.bin_accum;
        end

        result.ok     = good && (v <= max_value);
        result.value  = result.ok ? v : '0;
        result.format = fmt;
    end

endmodule

[rtl/radix_suffix_literal_parser.sv]
// Top level of the radix-suffix literal parser: input register, parse state,
// final decision and result register. Depends on rslp_pkg, rslp_state, rslp_resolve.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------
//   req      | req_valid / req_ready | req_data  (char_code, is_final)
//   rsp      | rsp_valid / rsp_ready | rsp_data  (ok, value, format)
//   cfg      | cfg_we                | cfg_wdata (max_value)
//
// One character per cycle while no final character is held; a final character's
// result passes through the input register and then the result register.
// Reset clears the parse state, empties both registers and sets max_value
// to 65535. A non-final character never waits on the rsp side; a final
// character holds in the input register only while an earlier result is unread.

module radix_suffix_literal_parser
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  rslp_pkg::req_t                req_data,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output rslp_pkg::rsp_t                rsp_data,
    input  logic                          cfg_we,
    input  logic [rslp_pkg::ValW-1:0]     cfg_wdata
);

    logic                        s1_valid_reg;
    rslp_pkg::req_t              s1_item_reg;
    logic                        rsp_valid_reg;
    rslp_pkg::rsp_t              rsp_data_reg;
    logic [rslp_pkg::ValW-1:0]   max_reg;

    logic                        advance;
    rslp_pkg::parse_state_t      cur;
    rslp_pkg::dec_state_t        dec_upd;
    rslp_pkg::rsp_t              result;

    assign advance   = s1_valid_reg
                     && (!s1_item_reg.is_final || !rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    rslp_state u_state
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .item    (s1_item_reg),
        .cur     (cur),
        .dec_upd (dec_upd)
    );

    rslp_resolve u_resolve
    (
        .cur       (cur),
        .dec_upd   (dec_upd),
        .char_code (s1_item_reg.char_code),
        .max_value (max_reg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            s1_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            s1_item_reg <= req_data;
        end
    end

    // hold the result until the rsp transaction completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance && s1_item_reg.is_final)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_item_reg.is_final)
        begin
            rsp_data_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= rslp_pkg::MAX_RESET;
        end
        else if (cfg_we)
        begin
            max_reg <= cfg_wdata;
        end
    end

endmodule

[tb/sv/radix_suffix_literal_parser_checker.sv]
// Result checker for the radix-suffix literal parser: watches the req, rsp and cfg
// ports, predicts each literal's result and compares it field by field.
// Depends on rslp_pkg.
`timescale 1ns / 100ps

module radix_suffix_literal_parser_checker
    import rslp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  req_t              req_data,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  rsp_t              rsp_data,
    input  logic              cfg_we,
    input  logic [ValW-1:0]   cfg_wdata,
    output int                fail_count,
    output int                outstanding,
    output int                results_seen
);

    // predicted parse state, one copy per reading
    logic [DecW-1:0] dec_mag;
    logic [ValW-1:0] hex_val;
    logic [ValW-1:0] bin_val;
    logic            hex_ovf;
    logic            bin_ovf;
    logic            dec_live;
    logic            hex_live;
    logic            bin_live;
    logic            neg_sign;
    logic            got_digit;
    logic            got_char;
    logic [ValW-1:0] max_copy;

    rsp_t            pending_results[$];
    rsp_t            want;
    rsp_t            pred;
    int              mismatches;
    int              results;

    function automatic void clear_literal();
        dec_mag   = '0;
        hex_val   = '0;
        bin_val   = '0;
        hex_ovf   = 1'b0;
        bin_ovf   = 1'b0;
        dec_live  = 1'b1;
        hex_live  = 1'b1;
        bin_live  = 1'b1;
        neg_sign  = 1'b0;
        got_digit = 1'b0;
        got_char  = 1'b0;
    endfunction

    // bit 4 flags a hex digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= CH_ZERO && c <= CH_NINE)
            return {1'b1, c[3:0]};
        if (c >= CH_UPPER_A && c <= CH_UPPER_F)
        begin
            d = c - CH_UPPER_A + 8'd10;
            return {1'b1, d[3:0]};
        end
        if (c >= CH_LOWER_A && c <= CH_LOWER_F)
        begin
            d = c - CH_LOWER_A + 8'd10;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic rsp_t make_result(input logic good, input logic [ValW-1:0] v,
                                         input logic [1:0] fmt);
        rsp_t r;
        r.ok     = good && (v <= max_copy);
        r.value  = r.ok ? v : '0;
        r.format = fmt;
        return r;
    endfunction

    // advance the parse by one character; returns 1 when a result is due
    function automatic bit literal_step(input req_t rq, output rsp_t res);
        logic [7:0]      c;
        logic [ProdW-1:0] prod;
        logic [DecW-1:0] mag;
        logic [4:0]      nib;
        logic            good;
        c   = rq.char_code;
        res = '0;

        if (!got_char && c == CH_MINUS)
            neg_sign = 1'b1;
        else if (c >= CH_ZERO && c <= CH_NINE)
        begin
            got_digit = 1'b1;
            prod      = {3'b000, dec_mag} * 20'd10 + {12'd0, c - CH_ZERO};
            dec_mag   = (prod > DEC_SAT) ? DEC_SAT : prod[DecW-1:0];
        end
        else
            dec_live = 1'b0;

        if (!rq.is_final)
        begin
            nib = hex_nibble(c);
            if (!nib[4])
                hex_live = 1'b0;
            else
            begin
                if (hex_val[15:12] != 4'd0)
                    hex_ovf = 1'b1;
                hex_val = {hex_val[11:0], nib[3:0]};
            end
            if (c == CH_ZERO || c == CH_ONE)
            begin
                if (bin_val[15])
                    bin_ovf = 1'b1;
                bin_val = {bin_val[14:0], c[0]};
            end
            else
                bin_live = 1'b0;
            got_char = 1'b1;
            return 1'b0;
        end

        // decimal first, then hex, then binary
        if (dec_live && got_digit)
        begin
            good = 1'b1;
            mag  = dec_mag;
            if (neg_sign && dec_mag != '0)
            begin
                if (dec_mag > NEG_BASE)
                    good = 1'b0;
                else
                    mag = NEG_BASE - dec_mag;
            end
            else if (dec_mag > VAL_MAX)
                good = 1'b0;
            res = make_result(good, mag[ValW-1:0], FMT_DEC);
        end
        else if ((c == CH_UPPER_H || c == CH_LOWER_H) && got_char && hex_live)
            res = make_result(!hex_ovf, hex_val, FMT_HEX);
        else if ((c == CH_UPPER_B || c == CH_LOWER_B) && got_char && bin_live)
            res = make_result(!bin_ovf, bin_val, FMT_BIN);
        else
        begin
            res.ok     = 1'b0;
            res.value  = '0;
            res.format = FMT_NONE;
        end
        clear_literal();
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_literal();
            max_copy = MAX_RESET;
            pending_results.delete();
            mismatches = 0;
            results    = 0;
            fail_count   <= 0;
            outstanding  <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                results++;
                if (pending_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("[%0t] unexpected result: ok=%0b value=%h format=%0d",
                                 $realtime, rsp_data.ok, rsp_data.value, rsp_data.format);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp_data.ok !== want.ok || rsp_data.value !== want.value ||
                        rsp_data.format !== want.format)
                    begin
                        if (mismatches < 10)
                            $display({"[%0t] mismatch: expected ok=%0b value=%h format=%0d,",
                                      " got ok=%0b value=%h format=%0d"},
                                     $realtime, want.ok, want.value, want.format,
                                     rsp_data.ok, rsp_data.value, rsp_data.format);
                        mismatches++;
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                if (literal_step(req_data, pred))
                    pending_results.push_back(pred);
            end
            if (cfg_we)
                max_copy = cfg_wdata;
            fail_count   <= mismatches;
            outstanding  <= pending_results.size();
            results_seen <= results;
        end
    end

endmodule

[tb/sv/radix_suffix_literal_parser_tb.sv]
// Testbench top for the radix-suffix literal parser: clock, reset, character
// stimulus, receiver back-pressure and verdict. Depends on rslp_pkg, the RTL
// and radix_suffix_literal_parser_checker.
`timescale 1ns / 100ps

module radix_suffix_literal_parser_tb;
    import rslp_pkg::*;

    localparam int ItemTarget = 1450;
    localparam int HoldCycles = 300;
    localparam int Phases     = 5;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            req_valid;
    logic            req_ready;
    req_t            req_data;
    logic            rsp_valid;
    logic            rsp_ready;
    rsp_t            rsp_data;
    logic            cfg_we;
    logic [ValW-1:0] cfg_wdata;
    logic            rx_ready;
    logic            hold_off;

    int              fail_count;
    int              outstanding;
    int              results_seen;
    int              items_sent;
    int              literals_sent;
    int              settings_used;
    logic [ValW-1:0] cur_max;
    bit              tx_calm;
    logic [7:0]      lit[$];

    always #1 clk = ~clk;

    assign rsp_ready = rx_ready && !hold_off;

    radix_suffix_literal_parser dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    radix_suffix_literal_parser_checker u_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req_data     (req_data),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .rsp_data     (rsp_data),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .results_seen (results_seen)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_char(input logic [7:0] c, input logic fin);
        int gap;
        gap = pick_gap(tx_calm);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid          <= 1'b1;
        req_data.char_code <= c;
        req_data.is_final  <= fin;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_literal();
        for (int i = 0; i < lit.size(); i++)
            send_char(lit[i], i == lit.size() - 1);
        literals_sent++;
    endtask

    task automatic send_text(input string s);
        lit.delete();
        for (int i = 0; i < s.len(); i++)
            lit.push_back(s[i]);
        send_literal();
    endtask

    task automatic push_dec(input int unsigned n);
        int unsigned d[$];
        do
        begin
            d.push_front(n % 10);
            n = n / 10;
        end
        while (n != 0);
        foreach (d[i])
            lit.push_back(CH_ZERO + d[i][7:0]);
    endtask

    task automatic push_hex(input int unsigned n, input int ndig);
        logic [3:0] nib;
        for (int i = ndig - 1; i >= 0; i--)
        begin
            nib = 4'((n >> (4 * i)) & 32'hF);
            if (nib < 10)
                lit.push_back(CH_ZERO + nib);
            else if ($urandom_range(0, 1))
                lit.push_back(CH_UPPER_A + nib - 8'd10);
            else
                lit.push_back(CH_LOWER_A + nib - 8'd10);
        end
    endtask

    task automatic push_bin(input int unsigned n, input int nbits);
        for (int i = nbits - 1; i >= 0; i--)
            lit.push_back(((n >> i) & 1) ? CH_ONE : CH_ZERO);
    endtask

    task automatic gen_dec();
        bit          neg;
        int unsigned n;
        neg = ($urandom_range(0, 3) == 0);
        if (neg)
            lit.push_back(CH_MINUS);
        case ($urandom_range(0, 3))
            0: n = $urandom_range(0, 999);
            1: n = $urandom_range(0, 70000);
            2:
            begin
                case ($urandom_range(0, 5))
                    0: n = 0;
                    1: n = 65535;
                    2: n = 65536;
                    3: n = 65537;
                    4: n = 99999;
                    default: n = $urandom_range(100000, 99999999);
                endcase
            end
            default:
            begin
                // land right at the max register or one past it
                if (neg)
                    n = 65536 - cur_max - $urandom_range(0, 1);
                else
                    n = cur_max + $urandom_range(0, 1);
            end
        endcase
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) lit.push_back(CH_ZERO);
        push_dec(n);
    endtask

    task automatic gen_hex();
        int unsigned n;
        int          ndig;
        case ($urandom_range(0, 7))
            0:
            begin
                ndig = 5;
                n    = cur_max + $urandom_range(0, 1);
            end
            1:
            begin
                ndig = $urandom_range(5, 7);
                n    = $urandom() & ((1 << (4 * ndig)) - 1);
                if ($urandom_range(0, 1))
                    n = n & 16'hFFFF;
            end
            default:
            begin
                ndig = $urandom_range(1, 4);
                n    = $urandom() & ((1 << (4 * ndig)) - 1);
            end
        endcase
        push_hex(n, ndig);
        lit.push_back($urandom_range(0, 1) ? CH_UPPER_H : CH_LOWER_H);
    endtask

    task automatic gen_bin();
        int unsigned n;
        int          nbits;
        case ($urandom_range(0, 5))
            0:
            begin
                nbits = 17;
                n     = cur_max + $urandom_range(0, 1);
            end
            1:
            begin
                nbits = $urandom_range(9, 20);
                n     = $urandom() & ((1 << nbits) - 1);
                if ($urandom_range(0, 1))
                    n = n & 16'hFFFF;
            end
            default:
            begin
                nbits = $urandom_range(1, 8);
                n     = $urandom() & ((1 << nbits) - 1);
            end
        endcase
        push_bin(n, nbits);
        lit.push_back($urandom_range(0, 1) ? CH_UPPER_B : CH_LOWER_B);
    endtask

    task automatic make_literal();
        int r;
        int pos;
        lit.delete();
        r = $urandom_range(0, 99);
        if (r < 85)
        begin
            case ($urandom_range(0, 2))
                0: gen_dec();
                1: gen_hex();
                default: gen_bin();
            endcase
            // break a share of the well-formed literals
            if (r >= 70)
            begin
                pos = $urandom_range(0, lit.size() - 1);
                case ($urandom_range(0, 3))
                    0: lit[pos] = 8'($urandom_range(0, 255));
                    1: if (lit.size() > 1) void'(lit.pop_back());
                    2: lit.insert(pos, CH_MINUS);
                    default: lit.push_back($urandom_range(0, 1) ? CH_LOWER_H : CH_UPPER_B);
                endcase
            end
        end
        else
            repeat ($urandom_range(1, 4)) lit.push_back(8'($urandom_range(0, 255)));
    endtask

    // hold until every result is out, then let the pipe settle
    task automatic drain();
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_max(input logic [ValW-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        cur_max = v;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        logic [ValW-1:0] max_plan[Phases];
        int              phase_end;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_data  <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        cur_max       = MAX_RESET;
        tx_calm       = 1'b0;
        items_sent    = 0;
        literals_sent = 0;
        settings_used = 1;
        max_plan = '{16'd0, 16'hFFFF, 16'd255, 16'($urandom_range(2, 65534)), 16'd1};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: lone characters, signed zero, limits, overflow
        send_text("7");
        send_text("H");
        send_text("-");
        send_text("-0");
        send_text("aH");
        send_text("1b");
        lit.delete();
        lit.push_back(8'hFF);
        send_literal();
        lit.delete();
        lit.push_back(8'h00);
        send_literal();
        send_text("-65536");
        send_text("10000h");
        req_valid <= 1'b0;
        drain();

        for (int p = 0; p < Phases; p++)
        begin
            write_max(max_plan[p]);
            tx_calm   = (p == 2);
            phase_end = items_sent + (ItemTarget - items_sent) / (Phases - p);
            while (items_sent < phase_end)
            begin
                make_literal();
                send_literal();
            end
            req_valid <= 1'b0;
            drain();
        end

        $display("Covered %0d characters in %0d literals under %0d max settings.",
                 items_sent, literals_sent, settings_used);
        $display("Compared %0d results, %0d failed.", results_seen, fail_count);
        if (fail_count == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // receiver: random stalls with occasional always-ready stretches
    initial
    begin
        int g;
        bit calm;
        rx_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            calm = ($urandom_range(0, 9) == 0);
            g    = pick_gap(calm);
            if (g > 0)
            begin
                rx_ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            rx_ready <= 1'b1;
            repeat (calm ? 40 : $urandom_range(1, 6)) @(posedge clk);
        end
    end

    // hold off the receiver while characters keep coming, so the input stalls
    initial
    begin
        hold_off <= 1'b0;
        wait (items_sent >= 600);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
rtl/rslp_pkg.sv
rtl/rslp_state.sv
rtl/rslp_resolve.sv
rtl/radix_suffix_literal_parser.sv
tb/sv/radix_suffix_literal_parser_checker.sv
tb/sv/radix_suffix_literal_parser_tb.sv
